[rtl/pra_pkg.sv]
// Shared types and constants for the page run allocator.
`timescale 1ns / 1ps
`default_nettype none

package pra_pkg;

    localparam int PAGE_SHIFT = 12;
    localparam int REQ_W      = 23;
    localparam int ADDR_W     = 22;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 11;
    localparam int FPAGE_W    = ADDR_W - PAGE_SHIFT;
    localparam int WANT_W     = REQ_W - PAGE_SHIFT + 1;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 24;

    localparam logic [CFG_W-1:0] PAGES_AVAIL_RESET = 11'd1024;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        KIND_FREE = 2'd0,
        KIND_HEAD = 2'd1,
        KIND_CONT = 2'd2,
        KIND_RSVD = 2'd3
    } kind_t;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_FILL  = 7'b0001000,
        ST_FCHK  = 7'b0010000,
        ST_FCLR  = 7'b0100000,
        ST_RESP  = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

[rtl/page_run_allocator_unit.sv]
// First-fit page run allocator over a page map held in one synchronous memory.
`timescale 1ns / 1ps
`default_nettype none

// One request at a time. After reset the page map is swept once, one entry per cycle,
// with s_tready low; configuration writes are taken throughout. An allocate request
// walks the map through the single read port at one entry per cycle, jumping over
// allocated runs, then writes the run one page per cycle. A free request reads the
// head page and clears the run one page per cycle. The next request is taken while
// a result still waits in the output register.
module page_run_allocator_unit #(
    parameter int MAX_PAGES = 1024
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // [22:0] request_bytes, [44:23] free_addr, [47:45] zero
    input  wire  [pra_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] func
    input  wire                            s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // [21:0] block_addr, [23:22] status
    output logic [pra_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [pra_pkg::CFG_W-1:0]      cfg_data
);

    localparam int PW = $clog2(MAX_PAGES);
    localparam int CW = (PW + 1 > 12) ? PW + 1 : 12;
    localparam logic [CW-1:0] MAXP = CW'(MAX_PAGES);
    localparam logic [PW-1:0] LAST_PAGE = PW'(MAX_PAGES - 1);

    typedef struct packed {
        pra_pkg::kind_t  kind;
        logic [PW-1:0]   val;
    } entry_t;

    entry_t page_map_mem [MAX_PAGES];

    pra_pkg::state_t state_reg, state_next;
    logic [pra_pkg::CFG_W-1:0]    pages_avail_reg;
    logic [CW-1:0]                p_reg, p_next;
    logic [CW-1:0]                run_reg, run_next;
    logic [PW-1:0]                start_reg, start_next;
    logic [CW-1:0]                wants_reg, wants_next;
    logic [CW-1:0]                q_reg, q_next;
    logic [CW-1:0]                len_reg, len_next;
    logic [CW-1:0]                pg_reg, pg_next;
    logic [PW-1:0]                clr_reg, clr_next;
    logic [pra_pkg::ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [pra_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [pra_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    entry_t        rd_data_reg;
    logic [PW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    entry_t        wr_data;

    logic [CW-1:0]                 pa_ext;
    logic [CW-1:0]                 limit;
    logic [pra_pkg::REQ_W-1:0]     req_bytes;
    logic [pra_pkg::ADDR_W-1:0]    free_addr;
    logic [pra_pkg::WANT_W-1:0]    wants_in;
    logic [CW-1:0]                 wants_ext;
    logic [CW-1:0]                 pg_ext;
    logic [CW-1:0]                 step;
    logic [CW-1:0]                 clr_sum;
    logic [PW-1:0]                 fill_addr;
    logic                          accept;

    assign s_tready  = (state_reg == pra_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign accept    = s_tvalid && s_tready;

    assign req_bytes = s_tdata[pra_pkg::REQ_W-1:0];
    assign free_addr = s_tdata[pra_pkg::REQ_W+pra_pkg::ADDR_W-1:pra_pkg::REQ_W];
    assign wants_in  = pra_pkg::WANT_W'(req_bytes[pra_pkg::REQ_W-1:pra_pkg::PAGE_SHIFT])
                     + pra_pkg::WANT_W'(|req_bytes[pra_pkg::PAGE_SHIFT-1:0]);
    assign wants_ext = CW'(wants_in);
    assign pg_ext    = CW'(free_addr[pra_pkg::ADDR_W-1:pra_pkg::PAGE_SHIFT]);
    assign pa_ext    = CW'(pages_avail_reg);
    assign limit     = (pa_ext > MAXP) ? MAXP : pa_ext;
    assign step      = (rd_data_reg.val == '0) ? CW'(1) : CW'(rd_data_reg.val);
    assign clr_sum   = pg_reg + q_reg;
    assign fill_addr = start_reg + q_reg[PW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            page_map_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= page_map_mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        p_next          = p_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        wants_next      = wants_reg;
        q_next          = q_reg;
        len_next        = len_reg;
        pg_next         = pg_reg;
        clr_next        = clr_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '{kind: pra_pkg::KIND_FREE, val: '0};

        unique case (state_reg)
            pra_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data.kind = (clr_reg == '0) ? pra_pkg::KIND_RSVD : pra_pkg::KIND_FREE;
                clr_next = clr_reg + PW'(1);
                if (clr_reg == LAST_PAGE) begin
                    state_next = pra_pkg::ST_IDLE;
                end
            end
            pra_pkg::ST_IDLE: begin
                if (accept) begin
                    res_addr_next = '0;
                    if (s_tuser == pra_pkg::FUNC_ALLOC) begin
                        wants_next = wants_ext;
                        if (wants_ext == '0 || wants_ext >= limit) begin
                            res_status_next = pra_pkg::STATUS_NO_ROOM;
                            state_next      = pra_pkg::ST_RESP;
                        end else begin
                            rd_addr    = PW'(1);
                            p_next     = CW'(1);
                            run_next   = '0;
                            state_next = pra_pkg::ST_SCAN;
                        end
                    end else begin
                        pg_next = pg_ext;
                        if (pg_ext == '0 || pg_ext >= MAXP) begin
                            res_status_next = pra_pkg::STATUS_IGNORED;
                            state_next      = pra_pkg::ST_RESP;
                        end else begin
                            rd_addr    = pg_ext[PW-1:0];
                            state_next = pra_pkg::ST_FCHK;
                        end
                    end
                end
            end
            pra_pkg::ST_SCAN: begin
                if (p_reg >= limit) begin
                    res_status_next = pra_pkg::STATUS_NO_ROOM;
                    state_next      = pra_pkg::ST_RESP;
                end else begin
                    case (rd_data_reg.kind)
                        pra_pkg::KIND_FREE: begin
                            run_next = run_reg + CW'(1);
                            if (run_reg == '0) begin
                                start_next = p_reg[PW-1:0];
                            end
                            p_next = p_reg + CW'(1);
                            if (run_reg + CW'(1) == wants_reg) begin
                                q_next     = '0;
                                state_next = pra_pkg::ST_FILL;
                            end
                        end
                        pra_pkg::KIND_HEAD: begin
                            p_next   = p_reg + step;
                            run_next = '0;
                        end
                        default: begin
                            p_next   = p_reg + CW'(1);
                            run_next = '0;
                        end
                    endcase
                    rd_addr = p_next[PW-1:0];
                end
            end
            pra_pkg::ST_FILL: begin
                wr_en   = 1'b1;
                wr_addr = fill_addr;
                if (q_reg == '0) begin
                    wr_data = '{kind: pra_pkg::KIND_HEAD, val: wants_reg[PW-1:0]};
                end else begin
                    wr_data = '{kind: pra_pkg::KIND_CONT, val: start_reg};
                end
                q_next = q_reg + CW'(1);
                if (q_reg + CW'(1) == wants_reg) begin
                    res_status_next = pra_pkg::STATUS_DONE;
                    res_addr_next   = pra_pkg::ADDR_W'({start_reg,
                                                        {pra_pkg::PAGE_SHIFT{1'b0}}});
                    state_next      = pra_pkg::ST_RESP;
                end
            end
            pra_pkg::ST_FCHK: begin
                unique case (rd_data_reg.kind)
                    pra_pkg::KIND_HEAD: begin
                        len_next = CW'(rd_data_reg.val);
                        q_next   = '0;
                        res_status_next = pra_pkg::STATUS_DONE;
                        state_next = (rd_data_reg.val == '0) ? pra_pkg::ST_RESP
                                                             : pra_pkg::ST_FCLR;
                    end
                    pra_pkg::KIND_FREE: begin
                        res_status_next = pra_pkg::STATUS_DONE;
                        state_next      = pra_pkg::ST_RESP;
                    end
                    pra_pkg::KIND_CONT,
                    pra_pkg::KIND_RSVD: begin
                        res_status_next = pra_pkg::STATUS_IGNORED;
                        state_next      = pra_pkg::ST_RESP;
                    end
                endcase
            end
            pra_pkg::ST_FCLR: begin
                wr_en   = (clr_sum < MAXP);
                wr_addr = clr_sum[PW-1:0];
                q_next  = q_reg + CW'(1);
                if (q_reg + CW'(1) == len_reg) begin
                    state_next = pra_pkg::ST_RESP;
                end
            end
            pra_pkg::ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_status_reg, res_addr_reg};
                    state_next    = pra_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pra_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= pra_pkg::ST_CLEAR;
            clr_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            pages_avail_reg <= pra_pkg::PAGES_AVAIL_RESET;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                pages_avail_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg          <= p_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        wants_reg      <= wants_next;
        q_reg          <= q_next;
        len_reg        <= len_next;
        pg_reg         <= pg_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != pra_pkg::ST_IDLE)
        else $error("request accepted without leaving idle");

    a_fill_not_page0: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pra_pkg::ST_FILL) && wr_en |-> wr_addr != '0)
        else $error("allocation wrote the reserved page");

    a_scan_ptr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pra_pkg::ST_SCAN |-> p_reg != '0)
        else $error("scan pointer reached the reserved page");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[pra_pkg::M_DATA_W-1:pra_pkg::ADDR_W] == pra_pkg::STATUS_DONE
                   || m_tdata[pra_pkg::M_DATA_W-1:pra_pkg::ADDR_W] == pra_pkg::STATUS_NO_ROOM
                   || m_tdata[pra_pkg::M_DATA_W-1:pra_pkg::ADDR_W] == pra_pkg::STATUS_IGNORED))
        else $error("result carries an undefined status");

endmodule

`default_nettype wire

[bench/tb_page_run_allocator_unit.sv]
// Self-checking testbench for the page run allocator: directed and random requests.
`timescale 1ns / 1ps

module tb_page_run_allocator_unit;

    localparam int MAX_PAGES = 1024;
    localparam int PAGE_BYTES = 1 << pra_pkg::PAGE_SHIFT;
    localparam int MAX_REQ_BYTES = MAX_PAGES * PAGE_BYTES;
    localparam int RANDOM_REQUESTS = 470;
    localparam int PHASE_LEN = 50;

    typedef struct packed {
        logic [pra_pkg::STATUS_W-1:0] status;
        logic [pra_pkg::ADDR_W-1:0]   block_addr;
    } alloc_result_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [pra_pkg::S_DATA_W-1:0]   s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [pra_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [pra_pkg::CFG_W-1:0]      cfg_data;

    pra_pkg::kind_t              map_kind [MAX_PAGES];
    int unsigned                 map_val [MAX_PAGES];
    logic [pra_pkg::CFG_W-1:0]   pages_avail;

    alloc_result_t      pending_results [$];
    int                 mismatches;
    int                 out_stall;
    bit                 calm;

    page_run_allocator_unit #(
        .MAX_PAGES(MAX_PAGES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic alloc_result_t predict_request(
            input logic func,
            input logic [pra_pkg::REQ_W-1:0] bytes,
            input logic [pra_pkg::ADDR_W-1:0] faddr);
        alloc_result_t res;
        int unsigned   wants;
        int unsigned   limit;
        int unsigned   p;
        int unsigned   run;
        int unsigned   start;
        int unsigned   pg;
        bit            found;
        res.block_addr = '0;
        res.status = pra_pkg::STATUS_DONE;
        if (func == pra_pkg::FUNC_ALLOC) begin
            wants = (int'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
            limit = (pages_avail > MAX_PAGES) ? MAX_PAGES : pages_avail;
            found = 1'b0;
            start = 0;
            run = 0;
            p = 1;
            if (wants != 0 && wants < limit) begin
                while (p < limit && !found) begin
                    case (map_kind[p])
                        pra_pkg::KIND_FREE: begin
                            if (run == 0) start = p;
                            run++;
                            p++;
                            if (run == wants) found = 1'b1;
                        end
                        pra_pkg::KIND_HEAD: begin
                            p += (map_val[p] == 0) ? 1 : map_val[p];
                            run = 0;
                        end
                        default: begin
                            p++;
                            run = 0;
                        end
                    endcase
                end
            end
            if (!found) begin
                res.status = pra_pkg::STATUS_NO_ROOM;
            end else begin
                map_kind[start] = pra_pkg::KIND_HEAD;
                map_val[start] = wants;
                for (int q = start + 1; q < start + wants; q++) begin
                    map_kind[q] = pra_pkg::KIND_CONT;
                    map_val[q] = start;
                end
                res.block_addr = pra_pkg::ADDR_W'(start * PAGE_BYTES);
            end
        end else begin
            pg = faddr >> pra_pkg::PAGE_SHIFT;
            if (pg == 0 || pg >= MAX_PAGES || map_kind[pg] == pra_pkg::KIND_CONT
                    || map_kind[pg] == pra_pkg::KIND_RSVD) begin
                res.status = pra_pkg::STATUS_IGNORED;
            end else if (map_kind[pg] == pra_pkg::KIND_HEAD) begin
                run = map_val[pg];
                for (int q = 0; q < run && pg + q < MAX_PAGES; q++) begin
                    map_kind[pg + q] = pra_pkg::KIND_FREE;
                    map_val[pg + q] = 0;
                end
            end
        end
        return res;
    endfunction

    function automatic int unsigned find_live_head();
        int unsigned first;
        int unsigned pg;
        first = $urandom_range(1, MAX_PAGES - 1);
        for (int i = 0; i < MAX_PAGES - 1; i++) begin
            pg = 1 + (first - 1 + i) % (MAX_PAGES - 1);
            if (map_kind[pg] == pra_pkg::KIND_HEAD) return pg;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : result_check
        alloc_result_t got;
        alloc_result_t want;
        int            next_stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: addr=%h status=%0d",
                                 got.block_addr, got.status);
                end else begin
                    want = pending_results.pop_front();
                    if (got.block_addr !== want.block_addr || got.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected addr=%h status=%0d, ",
                                      "got addr=%h status=%0d"},
                                     want.block_addr, want.status, got.block_addr, got.status);
                    end
                end
                next_stall = calm ? 0 : $urandom_range(0, 15);
            end else begin
                next_stall = (out_stall > 0) ? out_stall - 1 : 0;
            end
            out_stall <= next_stall;
            m_tready <= (next_stall == 0);
        end
    end

    task automatic send_request(input logic func, input logic [pra_pkg::REQ_W-1:0] bytes,
                                input logic [pra_pkg::ADDR_W-1:0] faddr);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {3'b000, faddr, bytes};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_request(func, bytes, faddr));
    endtask

    task automatic alloc_bytes(input int unsigned bytes);
        send_request(pra_pkg::FUNC_ALLOC, pra_pkg::REQ_W'(bytes),
                     pra_pkg::ADDR_W'($urandom_range(0, MAX_REQ_BYTES - 1)));
    endtask

    task automatic free_addr(input int unsigned addr);
        send_request(pra_pkg::FUNC_FREE, pra_pkg::REQ_W'($urandom_range(0, MAX_REQ_BYTES)),
                     pra_pkg::ADDR_W'(addr));
    endtask

    // Hold off new requests until every outstanding result has been taken.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_page_limit(input logic [pra_pkg::CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pages_avail = value;
    endtask

    task automatic test_directed_alloc_free();
        calm = 1'b0;
        alloc_bytes(0);
        alloc_bytes(MAX_REQ_BYTES);
        alloc_bytes((MAX_PAGES - 1) * PAGE_BYTES);
        alloc_bytes(1);
        free_addr(PAGE_BYTES + 12'hfff);
        free_addr(0);
        free_addr(MAX_REQ_BYTES - 1);
        alloc_bytes(1);
        alloc_bytes(2 * PAGE_BYTES + 1);
        alloc_bytes(PAGE_BYTES);
        free_addr(3 * PAGE_BYTES);
        free_addr(PAGE_BYTES);
        free_addr(PAGE_BYTES);
        alloc_bytes(PAGE_BYTES);
        free_addr(2 * PAGE_BYTES);
        alloc_bytes(3 * PAGE_BYTES);
        alloc_bytes(600 * PAGE_BYTES - 5);
        alloc_bytes(4 * PAGE_BYTES);
        wait_idle();
    endtask

    task automatic test_page_limits();
        write_page_limit(11'd2047);
        alloc_bytes(PAGE_BYTES);
        write_page_limit(11'd100);
        alloc_bytes(PAGE_BYTES);
        free_addr(6 * PAGE_BYTES);
        free_addr(606 * PAGE_BYTES);
        alloc_bytes(PAGE_BYTES);
        write_page_limit(11'd0);
        alloc_bytes(PAGE_BYTES);
        write_page_limit(11'd1);
        alloc_bytes(1);
        write_page_limit(11'd2);
        alloc_bytes(PAGE_BYTES);
        free_addr(PAGE_BYTES);
        alloc_bytes(1);
        alloc_bytes(2 * PAGE_BYTES);
        write_page_limit(pra_pkg::PAGES_AVAIL_RESET);
    endtask

    task automatic test_random_traffic();
        int          sel;
        int unsigned head;
        int unsigned pick;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % PHASE_LEN == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    write_page_limit(pra_pkg::PAGES_AVAIL_RESET);
                else if (pick < 8)
                    write_page_limit(pra_pkg::CFG_W'($urandom_range(2, MAX_PAGES)));
                else if (pick == 8)
                    write_page_limit(11'd2047);
                else
                    write_page_limit(pra_pkg::CFG_W'($urandom_range(0, 2)));
            end
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                alloc_bytes(($urandom_range(1, 6) - 1) * PAGE_BYTES
                            + $urandom_range(1, PAGE_BYTES));
            end else if (sel < 60) begin
                alloc_bytes($urandom_range(0, MAX_REQ_BYTES));
            end else if (sel < 90) begin
                head = find_live_head();
                if (head != 0)
                    free_addr(head * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
                else
                    free_addr($urandom_range(0, MAX_REQ_BYTES - 1));
            end else begin
                free_addr($urandom_range(0, MAX_REQ_BYTES - 1));
            end
        end
        wait_idle();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = pra_pkg::FUNC_ALLOC;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        calm = 1'b0;
        pages_avail = pra_pkg::PAGES_AVAIL_RESET;
        for (int p = 0; p < MAX_PAGES; p++) begin
            map_kind[p] = pra_pkg::KIND_FREE;
            map_val[p] = 0;
        end
        map_kind[0] = pra_pkg::KIND_RSVD;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_alloc_free();
        test_page_limits();
        test_random_traffic();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
